@@ rtl/core/fnt_pkg.sv @@
// Shared widths, constants and pipeline payload types of the flat triangle normal unit.
`timescale 1ns / 1ps

package fnt_pkg;

    localparam int CW       = 16;
    localparam int FB       = 14;
    localparam int OW       = FB + 2;
    localparam int EW       = CW + 1;
    localparam int PW       = 2 * EW;
    localparam int NW       = 2 * CW + 3;
    localparam int LW       = $clog2(NW);
    localparam int NORM_POS = 29;
    localparam int UW       = NORM_POS + 1;
    localparam int SHW      = NW + NORM_POS;
    localparam int SW       = 2 * UW;
    localparam int SUMW     = SW + 2;
    localparam int SQW      = SUMW + 1;
    localparam int RW       = SUMW / 2;
    localparam int DVW      = RW + 1;
    localparam int QW       = FB + 2;
    localparam int DCW      = DVW + QW;

    typedef struct packed {
        logic [2:0] neg;
        logic       deg;
        logic       fin;
    } fnt_tag_t;

    typedef struct packed {
        logic signed [CW-1:0] a_x;
        logic signed [CW-1:0] a_y;
        logic signed [CW-1:0] a_z;
        logic signed [CW-1:0] b_x;
        logic signed [CW-1:0] b_y;
        logic signed [CW-1:0] b_z;
        logic signed [CW-1:0] c_x;
        logic signed [CW-1:0] c_y;
        logic signed [CW-1:0] c_z;
        logic                 final_triangle;
    } fnt_tri_t;

    typedef struct packed {
        logic signed [OW-1:0] unit_x;
        logic signed [OW-1:0] unit_y;
        logic signed [OW-1:0] unit_z;
        logic                 degenerate;
        logic                 final_normal;
    } fnt_res_t;

    typedef struct packed {
        logic [SUMW-1:0]       sum;
        logic [2:0][UW-1:0]    mag;
        fnt_tag_t              tag;
    } fnt_sq_t;

    typedef struct packed {
        logic [SQW-1:0]        num;
        logic [SQW-1:0]        root;
        logic [2:0][UW-1:0]    mag;
        fnt_tag_t              tag;
    } fnt_rt_t;

    typedef struct packed {
        logic [RW-1:0]         len;
        logic [2:0][UW-1:0]    mag;
        fnt_tag_t              tag;
    } fnt_len_t;

    typedef struct packed {
        logic [2:0][DCW-1:0]   rem;
        logic [2:0][QW-1:0]    quo;
        logic [DVW-1:0]        den;
        fnt_tag_t              tag;
    } fnt_dv_t;

endpackage

@@ rtl/core/fnt_if.sv @@
// Request channel interfaces for triangles in and normals out.
`timescale 1ns / 1ps

interface fnt_tri_if;
    logic                          valid;
    logic                          ready;
    logic signed [fnt_pkg::CW-1:0] a_x;
    logic signed [fnt_pkg::CW-1:0] a_y;
    logic signed [fnt_pkg::CW-1:0] a_z;
    logic signed [fnt_pkg::CW-1:0] b_x;
    logic signed [fnt_pkg::CW-1:0] b_y;
    logic signed [fnt_pkg::CW-1:0] b_z;
    logic signed [fnt_pkg::CW-1:0] c_x;
    logic signed [fnt_pkg::CW-1:0] c_y;
    logic signed [fnt_pkg::CW-1:0] c_z;
    logic                          final_triangle;

    modport source (output valid, a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z,
                    final_triangle, input ready);
    modport sink   (input valid, a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z,
                    final_triangle, output ready);
endinterface

interface fnt_nrm_if;
    logic                          valid;
    logic                          ready;
    logic signed [fnt_pkg::OW-1:0] unit_x;
    logic signed [fnt_pkg::OW-1:0] unit_y;
    logic signed [fnt_pkg::OW-1:0] unit_z;
    logic                          degenerate;
    logic                          final_normal;

    modport source (output valid, unit_x, unit_y, unit_z, degenerate, final_normal,
                    input ready);
    modport sink   (input valid, unit_x, unit_y, unit_z, degenerate, final_normal,
                    output ready);
endinterface

@@ rtl/core/fnt_front.sv @@
// Front pipeline: edges, cross product, magnitudes, normalising shift and sum of squares.
`timescale 1ns / 1ps

module fnt_front
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_valid,
    input  fnt_pkg::fnt_tri_t tri_d,
    output logic              out_valid,
    output fnt_pkg::fnt_sq_t  out_d
);

    localparam int EW   = fnt_pkg::EW;
    localparam int PW   = fnt_pkg::PW;
    localparam int NW   = fnt_pkg::NW;
    localparam int LW   = fnt_pkg::LW;
    localparam int UW   = fnt_pkg::UW;
    localparam int SHW  = fnt_pkg::SHW;
    localparam int SW   = fnt_pkg::SW;
    localparam int SUMW = fnt_pkg::SUMW;
    localparam int NS   = 9;

    logic [NS-1:0]          v_reg;
    fnt_pkg::fnt_tag_t      tag_reg  [NS];
    fnt_pkg::fnt_tag_t      tag_next [NS];

    logic signed [EW-1:0]   e1_reg [3];
    logic signed [EW-1:0]   e2_reg [3];
    logic signed [PW-1:0]   p_reg  [6];
    logic signed [NW-1:0]   n_reg  [3];
    logic [NW-1:0]          m4_reg [3];
    logic [NW-1:0]          m5_reg [3];
    logic [NW-1:0]          m6_reg [3];
    logic [NW-1:0]          big_reg;
    logic [LW-1:0]          pos_reg;
    logic [LW-1:0]          pos_next;
    logic [UW-1:0]          u_reg  [3];
    logic [UW-1:0]          ud_reg [3];
    logic [UW-1:0]          um_reg [3];
    logic [SW-1:0]          sq_reg [3];
    logic [SUMW-1:0]        sum_reg;
    logic [NW-1:0]          mag_next [3];
    logic [2:0]             neg_next;
    logic [NW-1:0]          big_next;
    logic [SHW-1:0]         wide_next [3];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            neg_next[i]  = n_reg[i][NW-1];
            mag_next[i]  = n_reg[i][NW-1] ? -n_reg[i] : n_reg[i];
            wide_next[i] = ({{(SHW-NW){1'b0}}, m6_reg[i]} << fnt_pkg::NORM_POS) >> pos_reg;
        end
        big_next = (m4_reg[0] > m4_reg[1]) ? m4_reg[0] : m4_reg[1];
        if (m4_reg[2] > big_next)
        begin
            big_next = m4_reg[2];
        end
        pos_next = '0;
        for (int k = 0; k < NW; k++)
        begin
            if (big_reg[k])
            begin
                pos_next = LW'(k);
            end
        end
        tag_next[0] = '{neg: 3'b000, deg: 1'b0, fin: tri_d.final_triangle};
        for (int k = 1; k < NS; k++)
        begin
            tag_next[k] = tag_reg[k-1];
        end
        tag_next[3].neg = neg_next;
        tag_next[4].deg = (big_next == '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= {v_reg[NS-2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < NS; k++)
            begin
                tag_reg[k] <= tag_next[k];
            end
            e1_reg[0] <= EW'(tri_d.b_x) - EW'(tri_d.a_x);
            e1_reg[1] <= EW'(tri_d.b_y) - EW'(tri_d.a_y);
            e1_reg[2] <= EW'(tri_d.b_z) - EW'(tri_d.a_z);
            e2_reg[0] <= EW'(tri_d.c_x) - EW'(tri_d.a_x);
            e2_reg[1] <= EW'(tri_d.c_y) - EW'(tri_d.a_y);
            e2_reg[2] <= EW'(tri_d.c_z) - EW'(tri_d.a_z);
            p_reg[0]  <= e1_reg[1] * e2_reg[2];
            p_reg[1]  <= e1_reg[2] * e2_reg[1];
            p_reg[2]  <= e1_reg[2] * e2_reg[0];
            p_reg[3]  <= e1_reg[0] * e2_reg[2];
            p_reg[4]  <= e1_reg[0] * e2_reg[1];
            p_reg[5]  <= e1_reg[1] * e2_reg[0];
            for (int i = 0; i < 3; i++)
            begin
                n_reg[i]  <= NW'(p_reg[2*i]) - NW'(p_reg[2*i+1]);
                m4_reg[i] <= mag_next[i];
                m5_reg[i] <= m4_reg[i];
                m6_reg[i] <= m5_reg[i];
                u_reg[i]  <= wide_next[i][UW-1:0];
                ud_reg[i] <= u_reg[i];
                um_reg[i] <= ud_reg[i];
                sq_reg[i] <= u_reg[i] * u_reg[i];
            end
            big_reg <= big_next;
            pos_reg <= pos_next;
            sum_reg <= SUMW'(sq_reg[0]) + SUMW'(sq_reg[1]) + SUMW'(sq_reg[2]);
        end
    end

    assign out_valid = v_reg[NS-1];
    assign out_d     = '{sum: sum_reg,
                         mag: {um_reg[2], um_reg[1], um_reg[0]},
                         tag: tag_reg[NS-1]};

endmodule

@@ rtl/core/fnt_sqrt.sv @@
// Integer square root, one result bit per pipeline stage.
`timescale 1ns / 1ps

module fnt_sqrt
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_valid,
    input  fnt_pkg::fnt_sq_t  in_d,
    output logic              out_valid,
    output fnt_pkg::fnt_len_t out_d
);

    localparam int RW  = fnt_pkg::RW;
    localparam int SQW = fnt_pkg::SQW;

    logic [RW-1:0]     v_reg;
    fnt_pkg::fnt_rt_t  head;
    fnt_pkg::fnt_rt_t  stage_reg [RW];

    assign head = '{num: SQW'(in_d.sum), root: '0, mag: in_d.mag, tag: in_d.tag};

    for (genvar k = 0; k < RW; k++)
    begin : g_step
        localparam logic [SQW-1:0] BIT = {{(SQW-1){1'b0}}, 1'b1} << (2 * (RW - 1 - k));
        fnt_pkg::fnt_rt_t cur;
        fnt_pkg::fnt_rt_t step_next;
        logic [SQW-1:0]   trial;

        if (k == 0)
        begin : g_first
            assign cur = head;
        end
        else
        begin : g_rest
            assign cur = stage_reg[k-1];
        end

        assign trial = cur.root + BIT;

        always_comb
        begin
            step_next = cur;
            if (cur.num >= trial)
            begin
                step_next.num  = cur.num - trial;
                step_next.root = (cur.root >> 1) + BIT;
            end
            else
            begin
                step_next.root = cur.root >> 1;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                stage_reg[k] <= step_next;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= {v_reg[RW-2:0], in_valid};
        end
    end

    assign out_valid = v_reg[RW-1];
    assign out_d     = '{len: stage_reg[RW-1].root[RW-1:0],
                         mag: stage_reg[RW-1].mag,
                         tag: stage_reg[RW-1].tag};

endmodule

@@ rtl/core/fnt_div.sv @@
// Three-lane restoring divider with rounding, clamp and sign restore.
`timescale 1ns / 1ps

module fnt_div
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_valid,
    input  fnt_pkg::fnt_len_t in_d,
    output logic              out_valid,
    output fnt_pkg::fnt_res_t out_d
);

    localparam int FB  = fnt_pkg::FB;
    localparam int OW  = fnt_pkg::OW;
    localparam int QW  = fnt_pkg::QW;
    localparam int DCW = fnt_pkg::DCW;
    localparam int DVW = fnt_pkg::DVW;
    localparam logic [QW-1:0] ONE = {{(QW-1){1'b0}}, 1'b1} << FB;

    logic [QW-1:0]     v_reg;
    fnt_pkg::fnt_dv_t  head;
    fnt_pkg::fnt_dv_t  stage_reg [QW];
    fnt_pkg::fnt_dv_t  last;
    logic [QW-1:0]     qc [3];
    logic [OW-1:0]     sv [3];

    always_comb
    begin
        head.den = {in_d.len, 1'b0};
        head.tag = in_d.tag;
        for (int i = 0; i < 3; i++)
        begin
            head.rem[i] = DCW'({in_d.mag[i], {(FB+1){1'b0}}}) + DCW'(in_d.len);
            head.quo[i] = '0;
        end
    end

    for (genvar k = 0; k < QW; k++)
    begin : g_step
        localparam int J = QW - 1 - k;
        fnt_pkg::fnt_dv_t cur;
        fnt_pkg::fnt_dv_t step_next;
        logic [DCW-1:0]   sub;

        if (k == 0)
        begin : g_first
            assign cur = head;
        end
        else
        begin : g_rest
            assign cur = stage_reg[k-1];
        end

        assign sub = DCW'(cur.den) << J;

        always_comb
        begin
            step_next = cur;
            for (int i = 0; i < 3; i++)
            begin
                if (cur.rem[i] >= sub)
                begin
                    step_next.rem[i]    = cur.rem[i] - sub;
                    step_next.quo[i][J] = 1'b1;
                end
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                stage_reg[k] <= step_next;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= {v_reg[QW-2:0], in_valid};
        end
    end

    assign last = stage_reg[QW-1];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            qc[i] = (last.quo[i] > ONE) ? ONE : last.quo[i];
            if (last.tag.deg)
            begin
                sv[i] = '0;
            end
            else
            begin
                sv[i] = last.tag.neg[i] ? -OW'(qc[i]) : OW'(qc[i]);
            end
        end
        out_d.unit_x       = sv[0];
        out_d.unit_y       = sv[1];
        out_d.unit_z       = sv[2];
        out_d.degenerate   = last.tag.deg;
        out_d.final_normal = last.tag.fin;
    end

    assign out_valid = v_reg[QW-1];

endmodule

@@ rtl/core/fnt_obuf.sv @@
// Two-entry output buffer that decouples the pipeline from the result sink.
`timescale 1ns / 1ps

module fnt_obuf
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push_valid,
    input  fnt_pkg::fnt_res_t push_d,
    output logic              en,
    output logic              out_valid,
    input  logic              out_ready,
    output fnt_pkg::fnt_res_t out_d
);

    fnt_pkg::fnt_res_t mem_reg [2];
    logic [1:0]        count_reg;
    logic [1:0]        count_next;
    logic              wr_reg;
    logic              rd_reg;
    logic              push;
    logic              pop;

    assign en        = (count_reg != 2'd2);
    assign out_valid = (count_reg != 2'd0);
    assign out_d     = mem_reg[rd_reg];
    assign push      = push_valid && en;
    assign pop       = out_valid && out_ready;

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            wr_reg    <= 1'b0;
            rd_reg    <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_reg <= ~wr_reg;
            end
            if (pop)
            begin
                rd_reg <= ~rd_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_reg] <= push_d;
        end
    end

endmodule

@@ rtl/core/flat_triangle_normal_unit.sv @@
// Top level of the flat triangle normal unit.
`timescale 1ns / 1ps

// Takes one triangle per clock and returns its unit face normal in signed Q1.14, in
// order, one result per triangle. The pipeline has 9 front stages for edges, cross
// product, normalising shift and sum of squares, 31 square-root stages and 16 divider
// stages, followed by the two-entry output buffer. Throughput is one triangle per
// cycle; the whole pipeline holds when the output buffer is full, so input requests
// are refused only while two results wait. A zero cross product returns a zero
// normal with degenerate set; final_triangle is carried through to final_normal.

module flat_triangle_normal_unit
(
    input  logic       clk,
    input  logic       rst_n,
    fnt_tri_if.sink    tri_in,
    fnt_nrm_if.source  nrm_out
);

    logic               en;
    fnt_pkg::fnt_tri_t  tri_d;
    logic               sq_valid;
    fnt_pkg::fnt_sq_t   sq_d;
    logic               len_valid;
    fnt_pkg::fnt_len_t  len_d;
    logic               res_valid;
    fnt_pkg::fnt_res_t  res_d;
    fnt_pkg::fnt_res_t  out_d;

    assign tri_d = '{a_x: tri_in.a_x, a_y: tri_in.a_y, a_z: tri_in.a_z,
                     b_x: tri_in.b_x, b_y: tri_in.b_y, b_z: tri_in.b_z,
                     c_x: tri_in.c_x, c_y: tri_in.c_y, c_z: tri_in.c_z,
                     final_triangle: tri_in.final_triangle};

    assign tri_in.ready = en;

    fnt_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (tri_in.valid),
        .tri_d     (tri_d),
        .out_valid (sq_valid),
        .out_d     (sq_d)
    );

    fnt_sqrt u_sqrt
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (sq_valid),
        .in_d      (sq_d),
        .out_valid (len_valid),
        .out_d     (len_d)
    );

    fnt_div u_div
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (len_valid),
        .in_d      (len_d),
        .out_valid (res_valid),
        .out_d     (res_d)
    );

    fnt_obuf u_obuf
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (res_valid),
        .push_d     (res_d),
        .en         (en),
        .out_valid  (nrm_out.valid),
        .out_ready  (nrm_out.ready),
        .out_d      (out_d)
    );

    assign nrm_out.unit_x       = out_d.unit_x;
    assign nrm_out.unit_y       = out_d.unit_y;
    assign nrm_out.unit_z       = out_d.unit_z;
    assign nrm_out.degenerate   = out_d.degenerate;
    assign nrm_out.final_normal = out_d.final_normal;

endmodule

@@ rtl/core/fnt_checker.sv @@
// Port-level assertions for the flat triangle normal unit and their bind.
`timescale 1ns / 1ps

module fnt_checker
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          out_valid,
    input  logic                          out_ready,
    input  logic signed [fnt_pkg::OW-1:0] unit_x,
    input  logic signed [fnt_pkg::OW-1:0] unit_y,
    input  logic signed [fnt_pkg::OW-1:0] unit_z,
    input  logic                          degenerate
);

    localparam int OW = fnt_pkg::OW;
    localparam logic signed [OW-1:0] ONE  = {{(OW-1){1'b0}}, 1'b1} <<< fnt_pkg::FB;
    localparam logic signed [OW-1:0] MONE = -ONE;

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result request dropped while stalled");

    a_deg_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && degenerate |-> unit_x == '0 && unit_y == '0 && unit_z == '0)
        else $error("degenerate result with non-zero normal");

    a_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !degenerate |-> (unit_x != '0 || unit_y != '0 || unit_z != '0))
        else $error("zero normal without degenerate flag");

    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> unit_x <= ONE && unit_x >= MONE && unit_y <= ONE && unit_y >= MONE
                      && unit_z <= ONE && unit_z >= MONE)
        else $error("normal component beyond unit range");

endmodule

bind flat_triangle_normal_unit fnt_checker u_fnt_checker
(
    .clk        (clk),
    .rst_n      (rst_n),
    .out_valid  (nrm_out.valid),
    .out_ready  (nrm_out.ready),
    .unit_x     (nrm_out.unit_x),
    .unit_y     (nrm_out.unit_y),
    .unit_z     (nrm_out.unit_z),
    .degenerate (nrm_out.degenerate)
);

@@ tb/sv/flat_triangle_normal_unit_test.sv @@
// Testbench for the flat triangle normal unit: random and directed triangles checked against a predictor.
`timescale 1ns / 1ps

module flat_triangle_normal_unit_test;

    localparam int CW = fnt_pkg::CW;
    localparam int FB = fnt_pkg::FB;
    localparam int OW = fnt_pkg::OW;

    class normal_scoreboard;
        fnt_pkg::fnt_res_t pending[$];
        int errors;
        int checked;
        int degenerates;

        function fnt_pkg::fnt_res_t face_normal(fnt_pkg::fnt_tri_t t);
            longint e1x, e1y, e1z, e2x, e2y, e2z;
            longint n[3];
            longint unsigned m[3];
            longint unsigned big, sum, len, root, bit_v, rest, q;
            bit neg[3];
            fnt_pkg::fnt_res_t r;
            e1x = longint'(t.b_x) - longint'(t.a_x);
            e1y = longint'(t.b_y) - longint'(t.a_y);
            e1z = longint'(t.b_z) - longint'(t.a_z);
            e2x = longint'(t.c_x) - longint'(t.a_x);
            e2y = longint'(t.c_y) - longint'(t.a_y);
            e2z = longint'(t.c_z) - longint'(t.a_z);
            n[0] = e1y * e2z - e1z * e2y;
            n[1] = e1z * e2x - e1x * e2z;
            n[2] = e1x * e2y - e1y * e2x;
            big = 0;
            for (int i = 0; i < 3; i++)
            begin
                neg[i] = n[i] < 0;
                m[i] = neg[i] ? longint'(-n[i]) : n[i];
                if (m[i] > big)
                    big = m[i];
            end
            r = '0;
            r.final_normal = t.final_triangle;
            if (big == 0)
            begin
                r.degenerate = 1'b1;
                return r;
            end
            while (big < (64'd1 << 29))
            begin
                big <<= 1;
                for (int i = 0; i < 3; i++)
                    m[i] <<= 1;
            end
            while (big >= (64'd1 << 30))
            begin
                big >>= 1;
                for (int i = 0; i < 3; i++)
                    m[i] >>= 1;
            end
            sum = 0;
            for (int i = 0; i < 3; i++)
                sum += m[i] * m[i];
            rest = sum;
            root = 0;
            bit_v = 64'd1 << 62;
            while (bit_v > rest)
                bit_v >>= 2;
            while (bit_v != 0)
            begin
                if (rest >= root + bit_v)
                begin
                    rest -= root + bit_v;
                    root = (root >> 1) + bit_v;
                end
                else
                    root >>= 1;
                bit_v >>= 2;
            end
            len = root;
            for (int i = 0; i < 3; i++)
            begin
                q = (2 * (m[i] << FB) + len) / (2 * len);
                if (q > (64'd1 << FB))
                    q = 64'd1 << FB;
                if (i == 0) r.unit_x = neg[i] ? -q[OW-1:0] : q[OW-1:0];
                if (i == 1) r.unit_y = neg[i] ? -q[OW-1:0] : q[OW-1:0];
                if (i == 2) r.unit_z = neg[i] ? -q[OW-1:0] : q[OW-1:0];
            end
            return r;
        endfunction

        function void note_triangle(fnt_pkg::fnt_tri_t t);
            pending.push_back(face_normal(t));
        endfunction

        function void check_normal(fnt_pkg::fnt_res_t got);
            fnt_pkg::fnt_res_t exp_r;
            if (pending.size() == 0)
            begin
                $error("unexpected normal %p", got);
                errors++;
                return;
            end
            exp_r = pending.pop_front();
            checked++;
            if (exp_r.degenerate) degenerates++;
            if (got.unit_x !== exp_r.unit_x)
                begin $error("unit_x exp %0d got %0d", exp_r.unit_x, got.unit_x); errors++; end
            if (got.unit_y !== exp_r.unit_y)
                begin $error("unit_y exp %0d got %0d", exp_r.unit_y, got.unit_y); errors++; end
            if (got.unit_z !== exp_r.unit_z)
                begin $error("unit_z exp %0d got %0d", exp_r.unit_z, got.unit_z); errors++; end
            if (got.degenerate !== exp_r.degenerate)
                begin $error("degenerate exp %0b got %0b", exp_r.degenerate, got.degenerate);
                      errors++; end
            if (got.final_normal !== exp_r.final_normal)
                begin $error("final_normal exp %0b got %0b", exp_r.final_normal,
                             got.final_normal); errors++; end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    fnt_tri_if tri_in();
    fnt_nrm_if nrm_out();
    normal_scoreboard board;
    bit sending_done;

    flat_triangle_normal_unit dut (.clk(clk), .rst_n(rst_n), .tri_in(tri_in), .nrm_out(nrm_out));

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #5ms;
        $display("DONE: errors detected");
        $finish;
    end

    function automatic int gap_length();
        int p;
        p = $urandom_range(0, 99);
        if (p < 50) return 0;
        if (p < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    function automatic logic signed [CW-1:0] edge_coord();
        case ($urandom_range(0, 5))
            0: return 16'sh7fff;
            1: return 16'sh8000;
            2: return CW'($urandom_range(0, 15) - 8);
            default: return CW'($urandom());
        endcase
    endfunction

    task automatic send_triangle(fnt_pkg::fnt_tri_t t);
        int n;
        n = gap_length();
        if (n > 0)
        begin
            tri_in.valid <= 1'b0;
            repeat (n) @(posedge clk);
        end
        tri_in.valid <= 1'b1;
        {tri_in.a_x, tri_in.a_y, tri_in.a_z} <= {t.a_x, t.a_y, t.a_z};
        {tri_in.b_x, tri_in.b_y, tri_in.b_z} <= {t.b_x, t.b_y, t.b_z};
        {tri_in.c_x, tri_in.c_y, tri_in.c_z} <= {t.c_x, t.c_y, t.c_z};
        tri_in.final_triangle <= t.final_triangle;
        do @(posedge clk); while (!tri_in.ready);
        board.note_triangle(t);
    endtask

    task automatic send_random(int count);
        fnt_pkg::fnt_tri_t t;
        logic [159:0] rnd;
        for (int i = 0; i < count; i++)
        begin
            rnd = {$urandom(), $urandom(), $urandom(), $urandom(), $urandom()};
            t = rnd[$bits(fnt_pkg::fnt_tri_t)-1:0];
            case ($urandom_range(0, 9))
                0: begin t.b_x = t.a_x; t.b_y = t.a_y; t.b_z = t.a_z; end
                1: begin t.c_x = t.b_x; t.c_y = t.b_y; t.c_z = t.b_z; end
                2: begin
                    t.a_x = edge_coord(); t.a_y = edge_coord(); t.a_z = edge_coord();
                    t.b_x = edge_coord(); t.b_y = edge_coord(); t.b_z = edge_coord();
                    t.c_x = edge_coord(); t.c_y = edge_coord(); t.c_z = edge_coord();
                end
                3: begin
                    t.b_x = CW'(t.a_x + $urandom_range(0, 6) - 3);
                    t.b_y = CW'(t.a_y + $urandom_range(0, 6) - 3);
                    t.b_z = CW'(t.a_z + $urandom_range(0, 6) - 3);
                    t.c_x = CW'(t.a_x + $urandom_range(0, 6) - 3);
                    t.c_y = CW'(t.a_y + $urandom_range(0, 6) - 3);
                    t.c_z = CW'(t.a_z + $urandom_range(0, 6) - 3);
                end
                default: ;
            endcase
            send_triangle(t);
        end
    endtask

    task automatic send_directed();
        fnt_pkg::fnt_tri_t t;
        t = '0;
        send_triangle(t);
        t.b_x = 16'sd1; t.c_y = 16'sd1;
        send_triangle(t);
        t = '0; t.b_y = 16'sd1; t.c_z = 16'sd1; t.final_triangle = 1'b1;
        send_triangle(t);
        t = '0; t.b_z = 16'sd1; t.c_x = 16'sd1;
        send_triangle(t);
        t = '0; t.b_x = 16'sd2; t.c_x = -16'sd4;
        send_triangle(t);
        t = '0; t.a_x = 16'sh8000; t.a_y = 16'sh8000; t.a_z = 16'sh8000;
        t.b_x = 16'sh7fff; t.b_y = 16'sh8000; t.b_z = 16'sh8000;
        t.c_x = 16'sh8000; t.c_y = 16'sh7fff; t.c_z = 16'sh8000;
        send_triangle(t);
        t.c_z = 16'sh7fff;
        send_triangle(t);
        t = '0; t.a_x = 16'sh7fff; t.a_y = 16'sh7fff; t.a_z = 16'sh7fff;
        t.b_x = 16'sh8000; t.b_y = 16'sh7fff; t.b_z = 16'sh8000;
        t.c_x = 16'sh7fff; t.c_y = 16'sh8000; t.c_z = 16'sh8000;
        t.final_triangle = 1'b1;
        send_triangle(t);
        t = '0; t.b_x = 16'sd1; t.b_y = 16'sd1; t.b_z = 16'sd1;
        t.c_x = 16'sd1; t.c_y = 16'sd1; t.c_z = 16'sd2;
        send_triangle(t);
        t = '0; t.b_x = 16'sd3; t.c_y = 16'sd4; t.c_x = 16'sd1;
        send_triangle(t);
        t = '1;
        send_triangle(t);
        t = '0; t.b_x = 16'sd5; t.b_y = 16'sd5; t.c_x = 16'sd10; t.c_y = 16'sd10;
        send_triangle(t);
    endtask

    initial
    begin
        logic [159:0] rnd;
        board = new();
        rst_n = 1'b0;
        tri_in.valid = 1'b0;
        {tri_in.a_x, tri_in.a_y, tri_in.a_z} = '0;
        {tri_in.b_x, tri_in.b_y, tri_in.b_z} = '0;
        {tri_in.c_x, tri_in.c_y, tri_in.c_z} = '0;
        tri_in.final_triangle = 1'b0;
        nrm_out.ready = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        send_directed();
        send_random(200);
        for (int i = 0; i < 200; i++)
        begin
            rnd = {$urandom(), $urandom(), $urandom(), $urandom(), $urandom()};
            tri_in.valid <= 1'b1;
            {tri_in.a_x, tri_in.a_y, tri_in.a_z, tri_in.b_x, tri_in.b_y, tri_in.b_z,
             tri_in.c_x, tri_in.c_y, tri_in.c_z} <= rnd[9*CW-1:0];
            tri_in.final_triangle <= (i == 199);
            do @(posedge clk); while (!tri_in.ready);
            board.note_triangle({tri_in.a_x, tri_in.a_y, tri_in.a_z, tri_in.b_x, tri_in.b_y,
                                 tri_in.b_z, tri_in.c_x, tri_in.c_y, tri_in.c_z,
                                 tri_in.final_triangle});
        end
        tri_in.valid <= 1'b0;
        sending_done = 1'b1;
    end

    initial
    begin
        int stall;
        int hold;
        stall = 0;
        hold = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (nrm_out.valid && nrm_out.ready)
                board.check_normal({nrm_out.unit_x, nrm_out.unit_y, nrm_out.unit_z,
                                    nrm_out.degenerate, nrm_out.final_normal});
            if (sending_done && board.pending.size() == 0)
                break;
            if (hold > 0)
                hold--;
            else if (stall > 0)
                stall--;
            else if ($urandom_range(0, 9) == 0)
                stall = gap_length();
            else if ($urandom_range(0, 29) == 0)
                hold = $urandom_range(20, 80);
            nrm_out.ready <= (hold > 0) || (stall == 0);
        end
        nrm_out.ready <= 1'b1;
        repeat (80)
        begin
            @(posedge clk);
            if (nrm_out.valid)
                board.check_normal({nrm_out.unit_x, nrm_out.unit_y, nrm_out.unit_z,
                                    nrm_out.degenerate, nrm_out.final_normal});
        end
        $display("Checked %0d triangle normals, %0d of them degenerate,", board.checked,
                 board.degenerates);
        $display("with extreme coordinates, random stalls and back-to-back bursts.");
        if (board.errors == 0 && board.pending.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end
endmodule

@@ filelist.f @@
rtl/core/fnt_pkg.sv
rtl/core/fnt_if.sv
rtl/core/fnt_front.sv
rtl/core/fnt_sqrt.sv
rtl/core/fnt_div.sv
rtl/core/fnt_obuf.sv
rtl/core/flat_triangle_normal_unit.sv
rtl/core/fnt_checker.sv
tb/sv/flat_triangle_normal_unit_test.sv
